>>> rtl/chd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_pkg
// Types and constants shared by the color histogram difference block.
// ----------------------------------------------------------------------------
package chd_pkg;
  localparam int TABLE_DEPTH  = 256;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
  localparam int REPORT_LIMIT = 64;
  localparam int LIM_W        = 7;
  localparam int QUEUE_DEPTH  = 2;
  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(64);
  localparam logic [LIM_W-1:0] LIMIT_MAX   = LIM_W'(REPORT_LIMIT);
  localparam logic             ACT_ADD     = 1'b0;
  localparam logic             ACT_REPORT  = 1'b1;

  typedef struct packed {
    logic       action;
    logic       image_select;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } in_item_t;

  typedef struct packed {
    logic        diff_valid;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic [31:0] count_first;
    logic [31:0] count_second;
    logic        table_overflow;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        report;
    logic        second;
    logic [31:0] key;
  } cmd_t;
endpackage

>>> rtl/chd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_front
// Accepts requests, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
module chd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  chd_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output chd_pkg::cmd_t     cmd
);
  import chd_pkg::*;

  localparam int QP_W = $clog2(QUEUE_DEPTH);

  cmd_t            q_r [QUEUE_DEPTH];
  logic [QP_W-1:0] wp_r, rp_r;
  logic [QP_W:0]   fill_r;
  logic            push, pop;
  cmd_t            c;

  assign in_ready  = (fill_r != (QP_W+1)'(QUEUE_DEPTH));
  assign cmd_valid = (fill_r != '0);
  assign cmd       = q_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    c.report = (in_data.action == ACT_REPORT);
    c.second = in_data.image_select;
    c.key    = {in_data.red, in_data.green, in_data.blue, in_data.alpha};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= c;
    end
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      if (push) begin
        wp_r <= QP_W'((32'(wp_r) + 1) % QUEUE_DEPTH);
      end
      if (pop) begin
        rp_r <= QP_W'((32'(rp_r) + 1) % QUEUE_DEPTH);
      end
      fill_r <= fill_r + (QP_W+1)'(push) - (QP_W+1)'(pop);
    end
  end
endmodule

>>> rtl/chd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_back
// Table search, count update and difference report sequencer.
// ----------------------------------------------------------------------------
module chd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  chd_pkg::cmd_t              cmd,
  input  logic [chd_pkg::LIM_W-1:0]  limit,
  output logic                       out_valid,
  input  logic                       out_ready,
  output chd_pkg::out_item_t         out_data
);
  import chd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_RPT  = 3'd3;
  localparam logic [2:0] S_RCHK = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [31:0] key_m [TABLE_DEPTH];
  logic [31:0] c1_m  [TABLE_DEPTH];
  logic [31:0] c2_m  [TABLE_DEPTH];

  logic [2:0]       st_r;
  cmd_t             cur_r;
  logic [CNT_W-1:0] used_r, i_r;
  logic             ovf_r;
  logic [LIM_W-1:0] n_r, lim_r;
  logic [31:0]      rk_r, r1_r, r2_r;
  logic             pend_r;
  out_item_t        pend_d_r;
  logic             ov_r;
  out_item_t        od_r;
  logic             we;
  logic [IDX_W-1:0] wa;
  logic [31:0]      wk, w1, w2;
  logic             ibusy;
  logic             ov_load;

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign cmd_ready = (st_r == S_IDLE);
  assign ibusy     = (i_r < used_r);
  assign ov_load   = ((st_r == S_RPT) && pend_r && (!ov_r || out_ready)) ||
                     ((st_r == S_FIN) && (!ov_r || out_ready));

  always_ff @(posedge clk) begin
    if (we) begin
      key_m[wa] <= wk;
      c1_m[wa]  <= w1;
      c2_m[wa]  <= w2;
    end
    rk_r <= key_m[i_r[IDX_W-1:0]];
    r1_r <= c1_m[i_r[IDX_W-1:0]];
    r2_r <= c2_m[i_r[IDX_W-1:0]];
  end

  always_comb begin
    we = 1'b0;
    wa = i_r[IDX_W-1:0];
    wk = cur_r.key;
    w1 = r1_r;
    w2 = r2_r;
    if (st_r == S_CMP) begin
      if (ibusy && rk_r == cur_r.key) begin
        we = 1'b1;
        if (cur_r.second) begin
          w2 = (r2_r == '1) ? r2_r : r2_r + 32'd1;
        end else begin
          w1 = (r1_r == '1) ? r1_r : r1_r + 32'd1;
        end
      end else if (!ibusy && used_r != CNT_W'(TABLE_DEPTH)) begin
        we = 1'b1;
        wa = used_r[IDX_W-1:0];
        w1 = {31'd0, !cur_r.second};
        w2 = {31'd0, cur_r.second};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      used_r <= '0;
      ovf_r  <= 1'b0;
      ov_r   <= 1'b0;
      pend_r <= 1'b0;
      i_r    <= '0;
      n_r    <= '0;
    end else begin
      if (ov_r && out_ready && !ov_load) begin
        ov_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cur_r <= cmd;
            i_r   <= '0;
            n_r   <= '0;
            lim_r <= (limit > LIMIT_MAX) ? LIMIT_MAX : limit;
            pend_r <= 1'b0;
            st_r  <= S_RD;
          end
        end
        S_RD: begin
          st_r <= cur_r.report ? S_RCHK : S_CMP;
        end
        S_CMP: begin
          if (ibusy && rk_r == cur_r.key) begin
            st_r <= S_IDLE;
          end else if (!ibusy) begin
            if (used_r == CNT_W'(TABLE_DEPTH)) begin
              ovf_r <= 1'b1;
            end else begin
              used_r <= used_r + CNT_W'(1);
            end
            st_r <= S_IDLE;
          end else begin
            i_r  <= i_r + CNT_W'(1);
            st_r <= S_RD;
          end
        end
        S_RCHK: begin
          if (!ibusy || n_r >= lim_r) begin
            st_r <= S_FIN;
          end else if (r1_r != r2_r) begin
            st_r <= S_RPT;
          end else begin
            i_r  <= i_r + CNT_W'(1);
            st_r <= S_RD;
          end
        end
        S_RPT: begin
          if (!pend_r || !ov_r || out_ready) begin
            if (pend_r) begin
              ov_r <= 1'b1;
              od_r <= pend_d_r;
            end
            pend_r <= 1'b1;
            pend_d_r <= '{diff_valid: 1'b1, out_red: rk_r[31:24],
                          out_green: rk_r[23:16], out_blue: rk_r[15:8],
                          out_alpha: rk_r[7:0], count_first: r1_r,
                          count_second: r2_r, table_overflow: ovf_r, last: 1'b0};
            n_r  <= n_r + LIM_W'(1);
            i_r  <= i_r + CNT_W'(1);
            st_r <= S_RD;
          end
        end
        S_FIN: begin
          if (!ov_r || out_ready) begin
            ov_r <= 1'b1;
            if (pend_r) begin
              od_r <= {pend_d_r[$bits(out_item_t)-1:1], 1'b1};
            end else begin
              od_r <= '{diff_valid: 1'b0, out_red: 8'd0, out_green: 8'd0,
                        out_blue: 8'd0, out_alpha: 8'd0, count_first: 32'd0,
                        count_second: 32'd0, table_overflow: ovf_r, last: 1'b1};
            end
            used_r <= '0;
            ovf_r  <= 1'b0;
            pend_r <= 1'b0;
            st_r   <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/color_histogram_difference.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_histogram_difference
// Counts RGBA colors of two images and reports colors whose counts differ.
// ----------------------------------------------------------------------------
// channel | direction | payload
// in_     | input     | in_item_t: action, image select, RGBA
// out_    | output    | out_item_t: difference result, last marks end of report
// cfg_    | input     | max_differences, 7 bits
//
// A pixel is looked up by a single-port table read and compare loop that walks
// the entries from 0; a new color walks all used entries (at most 256) first.
// A report walks the entries, passing through a result state for each difference,
// and stretches while the result register is held by the receiver.
// Reset is synchronous; the table needs no clearing pass.
// Two-entry command queue lets requests be taken while the back end works.
// ----------------------------------------------------------------------------
module color_histogram_difference (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  chd_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output chd_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);
  import chd_pkg::*;

  logic             cmd_valid, cmd_ready;
  cmd_t             cmd;
  logic [LIM_W-1:0] limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit_r <= cfg_data;
    end
  end

  chd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  chd_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd(cmd), .limit(limit_r), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );
endmodule

>>> dv/color_histogram_difference_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_histogram_difference_test
// Feeds pixel and report requests to the color histogram difference block
// under random valid/ready gaps. A directed table covers the extremes, the
// report limit settings, a long receiver hold-off and count collisions.
// Random phases follow, each with a fresh max_differences. Every result is
// compared with a behavioral model of the color table.
// ----------------------------------------------------------------------------
module color_histogram_difference_test;
  import chd_pkg::*;

  localparam int CYCLE_MAX  = 3000000;
  localparam int DRAIN_WAIT = 2 * TABLE_DEPTH + 200;
  localparam int LONG_HOLD  = 600;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [6:0] cfg_data = '0;

  color_histogram_difference u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // color table model
  logic [31:0] color_key [TABLE_DEPTH];
  logic [31:0] cnt_first [TABLE_DEPTH];
  logic [31:0] cnt_second [TABLE_DEPTH];
  int          colors_used;
  logic        dropped_color;
  logic [6:0]  diff_limit;

  out_item_t   pending_diffs[$];
  int          errors = 0;
  int          cycles = 0;
  bit          quiet = 0;
  int          hold_len = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          long_left = 0;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } row_t;
  row_t rows[$];

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic out_item_t diff_entry(logic dv, logic [31:0] key, logic [31:0] c1,
                                           logic [31:0] c2, logic ovf, logic lst);
    out_item_t r;
    r.diff_valid = dv;
    {r.out_red, r.out_green, r.out_blue, r.out_alpha} = key;
    r.count_first = c1;
    r.count_second = c2;
    r.table_overflow = ovf;
    r.last = lst;
    return r;
  endfunction

  task automatic queue_diff(out_item_t r);
    pending_diffs = {pending_diffs, r};
  endtask

  task automatic predict_histogram(in_item_t req);
    logic [31:0] key;
    int lim;
    int n;
    bit hit;
    key = {req.red, req.green, req.blue, req.alpha};
    hit = 0;
    n = 0;
    if (req.action == ACT_REPORT) begin
      lim = (diff_limit > REPORT_LIMIT) ? REPORT_LIMIT : diff_limit;
      for (int i = 0; i < colors_used && n < lim; i++) begin
        if (cnt_first[i] != cnt_second[i]) begin
          queue_diff(diff_entry(1'b1, color_key[i], cnt_first[i],
                                cnt_second[i], dropped_color, 1'b0));
          n++;
        end
      end
      if (n == 0) begin
        queue_diff(diff_entry(1'b0, '0, '0, '0, dropped_color, 1'b0));
      end
      pending_diffs[pending_diffs.size()-1].last = 1'b1;
      colors_used = 0;
      dropped_color = 1'b0;
    end else begin
      for (int i = 0; i < colors_used && !hit; i++) begin
        if (color_key[i] == key) begin
          hit = 1;
          if (req.image_select) cnt_second[i] = bump(cnt_second[i]);
          else cnt_first[i] = bump(cnt_first[i]);
        end
      end
      if (!hit) begin
        if (colors_used >= TABLE_DEPTH) begin
          dropped_color = 1'b1;
        end else begin
          color_key[colors_used] = key;
          cnt_first[colors_used] = req.image_select ? 32'd0 : 32'd1;
          cnt_second[colors_used] = req.image_select ? 32'd1 : 32'd0;
          colors_used++;
        end
      end
    end
  endtask

  function automatic in_item_t pixel(logic img, logic [31:0] key);
    in_item_t p;
    p.action = ACT_ADD;
    p.image_select = img;
    {p.red, p.green, p.blue, p.alpha} = key;
    return p;
  endfunction

  function automatic in_item_t report_req();
    in_item_t p;
    {p.red, p.green, p.blue, p.alpha} = $urandom;
    p.image_select = 1'($urandom);
    p.action = ACT_REPORT;
    return p;
  endfunction

  task automatic add_row(in_item_t req, bit typed = 0, out_item_t want = '0);
    row_t r;
    r.req = req;
    r.typed = typed;
    r.want = want;
    rows = {rows, r};
  endtask

  task automatic send_request(in_item_t req);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_histogram(req);
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_input();
    while (pending_diffs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_limit(logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    diff_limit = v;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      long_left <= LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (long_left > 0) begin
      long_left <= long_left - 1;
      out_ready <= 1'b0;
    end else if (hold_len > 0) begin
      hold_len <= hold_len - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      hold_len <= $urandom_range(0, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_diffs.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_data);
        errors++;
      end else begin
        want = pending_diffs.pop_front();
        if (out_data.diff_valid !== want.diff_valid ||
            out_data.out_red !== want.out_red || out_data.out_green !== want.out_green ||
            out_data.out_blue !== want.out_blue || out_data.out_alpha !== want.out_alpha ||
            out_data.count_first !== want.count_first ||
            out_data.count_second !== want.count_second ||
            out_data.table_overflow !== want.table_overflow ||
            out_data.last !== want.last) begin
          $display("%0t: result mismatch, expected %h actual %h", $time, want, out_data);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int npix;
    int nkeys;
    logic [31:0] keys[8];
    colors_used = 0;
    dropped_color = 1'b0;
    diff_limit = LIMIT_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    add_row(report_req(), 1, diff_entry(1'b0, '0, '0, '0, 1'b0, 1'b1));
    add_row(pixel(1'b0, 32'h0000_0000));
    add_row(pixel(1'b1, 32'hFFFF_FFFF));
    add_row(pixel(1'b0, 32'hFFFF_FFFF));
    add_row(pixel(1'b0, 32'hFF00_00FF));
    add_row(pixel(1'b0, 32'hFF00_00FF));
    add_row(pixel(1'b1, 32'h00FF_FF00));
    add_row(report_req());
    add_row(pixel(1'b0, 32'h1234_5678));
    add_row(pixel(1'b1, 32'h1234_5678));
    add_row(report_req(), 1, diff_entry(1'b0, '0, '0, '0, 1'b0, 1'b1));
    add_row(pixel(1'b1, 32'hA5A5_A5A5));
    add_row(report_req(), 1, diff_entry(1'b1, 32'hA5A5_A5A5, 32'd0, 32'd1, 1'b0, 1'b1));
    foreach (rows[i]) begin
      send_request(rows[i].req);
      if (rows[i].typed) begin
        pending_diffs[pending_diffs.size()-1] = rows[i].want;
      end
    end
    rows.delete();
    wait_drained();

    // zero limit, then limit of one, then above the cap
    write_limit(7'd0);
    send_request(pixel(1'b0, 32'h0102_0304));
    send_request(report_req());
    wait_drained();
    write_limit(7'd1);
    send_request(pixel(1'b0, 32'h0102_0304));
    send_request(pixel(1'b1, 32'h0506_0708));
    send_request(report_req());
    wait_drained();
    write_limit(7'd127);

    // more differing colors than the cap, receiver held so the queue backs up
    for (int i = 0; i < REPORT_LIMIT + 2; i++) begin
      send_request(pixel(i[0], {8'h55, 8'(i >> 8), 8'(i), 8'hAA}));
    end
    hold_reqs++;
    send_request(report_req());
    send_request(pixel(1'b0, 32'hDEAD_BEEF));
    send_request(report_req());
    send_request(report_req());
    wait_drained();

    // random phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_limit(7'd64);
        1: write_limit(7'd63);
        2: write_limit(7'd0);
        default: write_limit(7'($urandom_range(0, 127)));
      endcase
      if (ph == 3) quiet = 1;
      for (int r = 0; r < 2; r++) begin
        nkeys = $urandom_range(1, 8);
        foreach (keys[k]) keys[k] = $urandom;
        npix = $urandom_range(1, 6);
        for (int p = 0; p < npix; p++) begin
          if ($urandom_range(0, 7) == 0) send_request(pixel(1'($urandom), $urandom));
          else send_request(pixel(1'($urandom), keys[$urandom_range(0, nkeys - 1)]));
        end
        send_request(report_req());
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
